// ----- rtl/core/hcbd_pkg.sv -----
// ----------------------------------------------------------------------------
// HTTP chunked body deframer package
// Shared byte codes, result codes and the result record that travels from
// the parser to the output register.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // Marks a byte that is not a hex digit.
    localparam logic [4:0] HEX_NONE = 5'd16;

    typedef enum logic [2:0] {
        KIND_HEADER  = 3'd0,
        KIND_SIZE    = 3'd1,
        KIND_PAYLOAD = 3'd2,
        KIND_DELIM   = 3'd3,
        KIND_RAW     = 3'd4,
        KIND_AFTER   = 3'd5
    } byte_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_DELIMITER = 2'd1,
        ERR_TOO_LONG  = 2'd2,
        ERR_EMPTY     = 2'd3
    } err_code_t;

    typedef struct packed {
        logic [7:0] data;
        byte_kind_t kind;
        logic       eof;
        err_code_t  err;
    } result_t;

    // Value of an ASCII hex digit, or HEX_NONE for any other byte.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        begin
            v = HEX_NONE;
            if (b >= 8'h30 && b <= 8'h39)
            begin
                v = 5'(b - 8'h30);
            end
            else if (b >= 8'h41 && b <= 8'h46)
            begin
                v = 5'(b - 8'h41 + 8'd10);
            end
            else if (b >= 8'h61 && b <= 8'h66)
            begin
                v = 5'(b - 8'h61 + 8'd10);
            end
            return v;
        end
    endfunction

endpackage

// ----- rtl/core/hcbd_in_stage.sv -----
// ----------------------------------------------------------------------------
// HCBD input register
// Holds one incoming byte until the parser consumes it.
// ----------------------------------------------------------------------------
module hcbd_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       advance,
    output logic       held_valid,
    output logic [7:0] held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= in_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

// ----- rtl/core/hcbd_parser.sv -----
// ----------------------------------------------------------------------------
// HCBD framing parser
// Per-byte state update for header skip, size lines, payload and delimiters.
// ----------------------------------------------------------------------------
module hcbd_parser #(
    parameter int MAX_DIGITS = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic              cfg_data,
    input  logic              advance,
    input  logic [7:0]        data,
    output hcbd_pkg::result_t result
);

    localparam int DcW = $clog2(MAX_DIGITS + 1);
    localparam logic [DcW-1:0] DcMax = DcW'(MAX_DIGITS);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SIZE,
        PH_SIZE_LF,
        PH_PAYLOAD,
        PH_DELIM_CR,
        PH_DELIM_LF,
        PH_RAW,
        PH_DONE
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [1:0]          match_reg, match_next;
    logic [31:0]         remaining_reg, remaining_next;
    logic [DcW-1:0]      count_reg, count_next;
    logic                done_reg, done_next;
    logic                eof_reg, eof_next;
    hcbd_pkg::err_code_t err_reg, err_next;
    logic                chunked_reg;
    hcbd_pkg::byte_kind_t kind;
    logic [4:0]          hex;
    logic [7:0]          expect_ch;

    always_comb
    begin
        phase_next     = phase_reg;
        match_next     = match_reg;
        remaining_next = remaining_reg;
        count_next     = count_reg;
        done_next      = done_reg;
        eof_next       = eof_reg;
        err_next       = err_reg;
        kind           = hcbd_pkg::KIND_AFTER;
        hex            = hcbd_pkg::hex_value(data);
        expect_ch      = match_reg[0] ? hcbd_pkg::CH_LF : hcbd_pkg::CH_CR;

        if (err_reg == hcbd_pkg::ERR_NONE && phase_reg != PH_DONE)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    kind = hcbd_pkg::KIND_HEADER;
                    if (data == expect_ch)
                    begin
                        if (match_reg == 2'd3)
                        begin
                            match_next     = 2'd0;
                            phase_next     = chunked_reg ? PH_SIZE : PH_RAW;
                            remaining_next = '0;
                            count_next     = '0;
                            done_next      = 1'b0;
                        end
                        else
                        begin
                            match_next = match_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        match_next = (data == hcbd_pkg::CH_CR) ? 2'd1 : 2'd0;
                    end
                end
                PH_SIZE:
                begin
                    kind = hcbd_pkg::KIND_SIZE;
                    if (data == hcbd_pkg::CH_CR)
                    begin
                        if (count_reg == '0)
                        begin
                            err_next = hcbd_pkg::ERR_EMPTY;
                        end
                        else
                        begin
                            phase_next = PH_SIZE_LF;
                        end
                    end
                    else if (!done_reg && hex != hcbd_pkg::HEX_NONE)
                    begin
                        if (count_reg >= DcMax)
                        begin
                            err_next = hcbd_pkg::ERR_TOO_LONG;
                        end
                        else
                        begin
                            remaining_next = {remaining_reg[27:0], hex[3:0]};
                            count_next     = count_reg + DcW'(1);
                        end
                    end
                    else
                    begin
                        // Extension text: the digits are over for this line.
                        done_next = 1'b1;
                    end
                end
                PH_SIZE_LF:
                begin
                    kind = hcbd_pkg::KIND_SIZE;
                    if (data != hcbd_pkg::CH_LF)
                    begin
                        err_next = hcbd_pkg::ERR_DELIMITER;
                    end
                    else if (remaining_reg == '0)
                    begin
                        // Terminating chunk; done now flags the final CR LF.
                        done_next  = 1'b1;
                        phase_next = PH_DELIM_CR;
                    end
                    else
                    begin
                        done_next  = 1'b0;
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    kind           = hcbd_pkg::KIND_PAYLOAD;
                    remaining_next = remaining_reg - 32'd1;
                    if (remaining_reg == 32'd1)
                    begin
                        phase_next = PH_DELIM_CR;
                    end
                end
                PH_DELIM_CR:
                begin
                    kind = hcbd_pkg::KIND_DELIM;
                    if (data == hcbd_pkg::CH_CR)
                    begin
                        phase_next = PH_DELIM_LF;
                    end
                    else
                    begin
                        err_next = hcbd_pkg::ERR_DELIMITER;
                    end
                end
                PH_DELIM_LF:
                begin
                    kind = hcbd_pkg::KIND_DELIM;
                    if (data != hcbd_pkg::CH_LF)
                    begin
                        err_next = hcbd_pkg::ERR_DELIMITER;
                    end
                    else if (done_reg)
                    begin
                        eof_next   = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next     = PH_SIZE;
                        remaining_next = '0;
                        count_next     = '0;
                        done_next      = 1'b0;
                    end
                end
                PH_RAW:
                begin
                    kind = hcbd_pkg::KIND_RAW;
                end
                default:
                begin
                    kind = hcbd_pkg::KIND_AFTER;
                end
            endcase
        end
    end

    assign result.data = data;
    assign result.kind = kind;
    assign result.eof  = eof_next;
    assign result.err  = err_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            match_reg     <= 2'd0;
            remaining_reg <= '0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            eof_reg       <= 1'b0;
            err_reg       <= hcbd_pkg::ERR_NONE;
            chunked_reg   <= 1'b1;
        end
        else
        begin
            if (cfg_write)
            begin
                chunked_reg <= cfg_data;
            end
            if (advance)
            begin
                phase_reg     <= phase_next;
                match_reg     <= match_next;
                remaining_reg <= remaining_next;
                count_reg     <= count_next;
                done_reg      <= done_next;
                eof_reg       <= eof_next;
                err_reg       <= err_next;
            end
        end
    end

endmodule

// ----- rtl/core/hcbd_out_stage.sv -----
// ----------------------------------------------------------------------------
// HCBD result register
// Holds one labeled byte until the consumer takes it.
// ----------------------------------------------------------------------------
module hcbd_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  hcbd_pkg::result_t result,
    output logic              can_load,
    output logic              out_valid,
    input  logic              out_ready,
    output hcbd_pkg::result_t held
);

    logic              valid_reg;
    logic              valid_next;
    hcbd_pkg::result_t result_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = can_load ? load : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign held      = result_reg;

endmodule

// ----- rtl/core/http_chunked_body_deframer.sv -----
// ----------------------------------------------------------------------------
// HTTP chunked body deframer
// Labels each byte of an HTTP response as header, size line, payload,
// delimiter, raw body or after end, and reports end of message and errors.
//
//   Channel   Signals                                                  Dir
//   input     in_valid, in_ready, in_byte                              in
//   result    out_valid, out_ready, out_byte, byte_kind, end_seen,
//             error_code                                               out
//   config    cfg_valid, cfg_ready, cfg_data                           in
//
// One byte per cycle sustained while the result port is ready; an accepted
// byte passes the input register, then the parser into the result register.
// Reset returns the parser to header scan with chunked mode on.
// A stalled result stops the parser and the input register fills, then
// in_ready drops; the configuration port is always ready.
// ----------------------------------------------------------------------------
module http_chunked_body_deframer #(
    parameter int MAX_DIGITS = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [2:0] byte_kind,
    output logic       end_seen,
    output logic [1:0] error_code,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);

    logic              held_valid;
    logic [7:0]        held_byte;
    logic              can_load;
    logic              advance;
    hcbd_pkg::result_t result;
    hcbd_pkg::result_t out_result;

    assign advance   = held_valid && can_load;
    assign cfg_ready = 1'b1;

    hcbd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    hcbd_parser #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .data      (held_byte),
        .result    (result)
    );

    hcbd_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .result    (result),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .held      (out_result)
    );

    assign out_byte   = out_result.data;
    assign byte_kind  = 3'(out_result.kind);
    assign end_seen   = out_result.eof;
    assign error_code = 2'(out_result.err);

endmodule
